FILE: src/pce_pkg.sv
package pce_pkg;

  localparam int VALUE_BITS    = 32;
  localparam int FRACTION_BITS = 16;

  // shift register for the multiplier / low product bits or the dividend / quotient, and the step counter
  localparam int SR_W  = VALUE_BITS + FRACTION_BITS;
  localparam int MAG_W = 2 * VALUE_BITS;
  localparam int CNT_W = $clog2(SR_W + 1);

  localparam logic [2:0] K_NUM   = 3'd0;
  localparam logic [2:0] K_PLUS  = 3'd1;
  localparam logic [2:0] K_MINUS = 3'd2;
  localparam logic [2:0] K_TIMES = 3'd3;
  localparam logic [2:0] K_DIV   = 3'd4;
  localparam logic [2:0] K_EQ    = 3'd5;
  localparam logic [2:0] K_CLEAR = 3'd6;
  localparam logic [2:0] K_NONE  = 3'd7;

  // last operation "none" shares the number code
  localparam logic [2:0] OP_NONE = K_NUM;

  localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef struct packed {
    logic [2:0]                   kind;
    logic signed [VALUE_BITS-1:0] value;
  } key_item_t;

  typedef struct packed {
    logic                         accepted;
    logic                         div_by_zero;
    logic signed [VALUE_BITS-1:0] current_result;
  } res_item_t;

  typedef struct packed {
    logic                         start;
    logic                         is_div;
    logic signed [VALUE_BITS-1:0] a;
    logic signed [VALUE_BITS-1:0] b;
  } arith_req_t;

  typedef struct packed {
    logic                         done;
    logic signed [VALUE_BITS-1:0] res;
  } arith_rsp_t;

endpackage

FILE: src/pce_arith.sv
module pce_arith (
  input  logic                clk,
  input  logic                rst,
  input  pce_pkg::arith_req_t req,
  output pce_pkg::arith_rsp_t rsp
);

  localparam int VB    = pce_pkg::VALUE_BITS;
  localparam int FB    = pce_pkg::FRACTION_BITS;
  localparam int SR_W  = pce_pkg::SR_W;
  localparam int MAG_W = pce_pkg::MAG_W;
  localparam int CNT_W = pce_pkg::CNT_W;

  localparam logic [MAG_W-1:0] LIM_NEG = MAG_W'(1) << (VB - 1);
  localparam logic [MAG_W-1:0] LIM_POS = LIM_NEG - MAG_W'(1);

  typedef enum logic [2:0] {
    A_IDLE = 3'b001,
    A_RUN  = 3'b010,
    A_FIN  = 3'b100
  } arith_state_t;

  arith_state_t state;
  logic              is_div;
  logic              neg;
  logic [VB-1:0]     opnd;
  logic [VB-1:0]     acc;
  logic [SR_W-1:0]   sr;
  logic [CNT_W-1:0]  cnt;
  logic              done;
  logic signed [VB-1:0] res;

  logic [VB-1:0]    a_u, b_u, mag_a, mag_b;
  logic [VB:0]      mul_sum;
  logic [VB:0]      div_t;
  logic [VB+1:0]    diff;
  logic             ge;
  logic [MAG_W-1:0] m;
  logic signed [VB-1:0] fin_res;

  always_comb begin
    a_u   = req.a;
    b_u   = req.b;
    mag_a = a_u[VB-1] ? (~a_u + VB'(1)) : a_u;
    mag_b = b_u[VB-1] ? (~b_u + VB'(1)) : b_u;

    // shift-add: one multiplier bit a cycle, low product bits drop into sr
    mul_sum = {1'b0, acc} + {1'b0, (sr[0] ? opnd : '0)};

    // restoring division: one quotient bit a cycle
    div_t = {acc, sr[SR_W-1]};
    diff  = {1'b0, div_t} - {2'b00, opnd};
    ge    = !diff[VB+1];

    if (is_div) begin
      m = MAG_W'(sr);
    end else begin
      m = {acc, sr[VB-1:0]} >> FB;
    end

    if (neg) begin
      fin_res = (m > LIM_NEG) ? pce_pkg::VAL_MIN : (~m[VB-1:0] + VB'(1));
    end else begin
      fin_res = (m > LIM_POS) ? pce_pkg::VAL_MAX : m[VB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == A_FIN);
      unique case (state)
        A_IDLE: if (req.start) state <= A_RUN;
        A_RUN:  if (cnt == CNT_W'(1)) state <= A_FIN;
        A_FIN:  state <= A_IDLE;
        default: state <= A_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      A_IDLE: begin
        if (req.start) begin
          is_div <= req.is_div;
          neg    <= req.a[VB-1] ^ req.b[VB-1];
          acc    <= '0;
          if (req.is_div) begin
            opnd <= mag_b;
            sr   <= SR_W'(mag_a) << FB;
            cnt  <= CNT_W'(SR_W);
          end else begin
            opnd <= mag_a;
            sr   <= SR_W'(mag_b);
            cnt  <= CNT_W'(VB);
          end
        end
      end
      A_RUN: begin
        cnt <= cnt - CNT_W'(1);
        if (is_div) begin
          acc <= ge ? diff[VB-1:0] : div_t[VB-1:0];
          sr  <= {sr[SR_W-2:0], ge};
        end else begin
          acc <= mul_sum[VB:1];
          sr  <= SR_W'({mul_sum[0], sr[VB-1:1]});
        end
      end
      A_FIN: res <= fin_res;
      default: ;
    endcase
  end

  assign rsp.done = done;
  assign rsp.res  = res;

endmodule

FILE: src/precedence_calculator_engine_top.sv
// Four-function calculator with operator precedence, signed Q16.16. One key
// item in, one result item out. Number and clear keys, and operator keys that
// close no times or divide step, return their result without the shared
// multiply/divide unit. A key that closes a times step or a divide step by a
// nonzero divisor waits for that unit, which resolves one multiplier or
// quotient bit per cycle. The next key is taken once the current one has been
// placed in the output register, even while that result is still stalled.
module precedence_calculator_engine_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               key_valid,
  output logic               key_stall,
  input  pce_pkg::key_item_t key,
  output logic               res_valid,
  input  logic               res_stall,
  output pce_pkg::res_item_t res
);

  localparam int VB = pce_pkg::VALUE_BITS;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EVAL  = 4'b0010,
    S_ARITH = 4'b0100,
    S_DONE  = 4'b1000
  } top_state_t;

  top_state_t state, state_next;

  logic [2:0]           kind_r;
  logic signed [VB-1:0] value_r;

  logic signed [VB-1:0] sum_value, sum_value_next;
  logic                 sum_present, sum_present_next;
  logic signed [VB-1:0] prod_value, prod_value_next;
  logic                 prod_present, prod_present_next;
  logic [2:0]           last_op, last_op_next;
  logic [2:0]           last_key, last_key_next;
  logic signed [VB-1:0] last_num, last_num_next;
  logic                 p_acc, p_acc_next;
  logic                 p_dz, p_dz_next;

  pce_pkg::arith_req_t arith_req;
  pce_pkg::arith_rsp_t arith_rsp;

  logic                 term, expr, is_op, from_arith, inv, cin, out_load;
  logic signed [VB-1:0] r0, add_a, add_b, add_sat;
  logic [VB:0]          add_full;
  logic signed [VB-1:0] cur;

  pce_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (arith_req),
    .rsp (arith_rsp)
  );

  assign key_stall = (state != S_IDLE);
  assign out_load  = (state == S_DONE) && (!res_valid || !res_stall);

  // one saturating adder: sum + term, with minus folded in as ~n + 1
  always_comb begin
    term       = (kind_r == pce_pkg::K_TIMES) || (kind_r == pce_pkg::K_DIV);
    expr       = (kind_r == pce_pkg::K_PLUS) || (kind_r == pce_pkg::K_MINUS);
    is_op      = expr || term || (kind_r == pce_pkg::K_EQ);
    from_arith = (state == S_ARITH);
    r0         = from_arith ? arith_rsp.res : last_num;
    inv        = !from_arith && (last_op == pce_pkg::K_MINUS);
    add_a      = term ? '0 : (sum_present ? sum_value : '0);
    add_b      = inv ? ~r0 : r0;
    cin        = inv && (r0 != pce_pkg::VAL_MIN);
    add_full   = {add_a[VB-1], add_a} + {add_b[VB-1], add_b} + (VB+1)'(cin);
    if (add_full[VB] != add_full[VB-1]) begin
      add_sat = add_full[VB] ? pce_pkg::VAL_MIN : pce_pkg::VAL_MAX;
    end else begin
      add_sat = add_full[VB-1:0];
    end
    cur = sum_present ? sum_value : (prod_present ? prod_value : '0);
  end

  always_comb begin
    state_next        = state;
    sum_value_next    = sum_value;
    sum_present_next  = sum_present;
    prod_value_next   = prod_value;
    prod_present_next = prod_present;
    last_op_next      = last_op;
    last_key_next     = last_key;
    last_num_next     = last_num;
    p_acc_next        = p_acc;
    p_dz_next         = p_dz;
    arith_req.start   = 1'b0;
    arith_req.is_div  = (last_op == pce_pkg::K_DIV);
    arith_req.a       = prod_value;
    arith_req.b       = last_num;

    unique case (state)
      S_IDLE: begin
        if (key_valid) state_next = S_EVAL;
      end
      S_EVAL: begin
        p_acc_next = 1'b0;
        p_dz_next  = 1'b0;
        state_next = S_DONE;
        priority if (kind_r == pce_pkg::K_NUM) begin
          if (last_key != pce_pkg::K_NUM) begin
            last_num_next = value_r;
            last_key_next = pce_pkg::K_NUM;
            p_acc_next    = 1'b1;
          end
        end else if (kind_r == pce_pkg::K_CLEAR) begin
          sum_value_next    = '0;
          sum_present_next  = 1'b0;
          prod_value_next   = '0;
          prod_present_next = 1'b0;
          last_op_next      = pce_pkg::OP_NONE;
          last_key_next     = pce_pkg::K_NONE;
          last_num_next     = '0;
          p_acc_next        = 1'b1;
        end else if (is_op && last_key == pce_pkg::K_NUM) begin
          priority if (last_op == pce_pkg::K_PLUS || last_op == pce_pkg::K_MINUS) begin
            if (term) begin
              prod_value_next   = add_sat;
              prod_present_next = 1'b1;
            end else begin
              sum_value_next    = add_sat;
              sum_present_next  = 1'b1;
              prod_value_next   = '0;
              prod_present_next = 1'b0;
            end
            last_op_next  = kind_r;
            last_key_next = kind_r;
            p_acc_next    = 1'b1;
          end else if (last_op == pce_pkg::K_TIMES) begin
            arith_req.start = 1'b1;
            state_next      = S_ARITH;
          end else if (last_op == pce_pkg::K_DIV) begin
            if (last_num == '0) begin
              p_dz_next = 1'b1;
            end else begin
              arith_req.start = 1'b1;
              state_next      = S_ARITH;
            end
          end else begin
            // no pending operation, or after equals
            if (term) begin
              sum_value_next    = '0;
              sum_present_next  = 1'b0;
              prod_value_next   = last_num;
              prod_present_next = 1'b1;
            end else if (expr) begin
              sum_value_next    = last_num;
              sum_present_next  = 1'b1;
              prod_value_next   = '0;
              prod_present_next = 1'b0;
            end
            last_op_next  = kind_r;
            last_key_next = kind_r;
            p_acc_next    = 1'b1;
          end
        end
      end
      S_ARITH: begin
        if (arith_rsp.done) begin
          if (term) begin
            prod_value_next   = add_sat;
            prod_present_next = 1'b1;
          end else begin
            sum_value_next    = add_sat;
            sum_present_next  = 1'b1;
            prod_value_next   = '0;
            prod_present_next = 1'b0;
          end
          last_op_next  = kind_r;
          last_key_next = kind_r;
          p_acc_next    = 1'b1;
          state_next    = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sum_value    <= '0;
      sum_present  <= 1'b0;
      prod_value   <= '0;
      prod_present <= 1'b0;
      last_op      <= pce_pkg::OP_NONE;
      last_key     <= pce_pkg::K_NONE;
      last_num     <= '0;
      p_acc        <= 1'b0;
      p_dz         <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      sum_value    <= sum_value_next;
      sum_present  <= sum_present_next;
      prod_value   <= prod_value_next;
      prod_present <= prod_present_next;
      last_op      <= last_op_next;
      last_key     <= last_key_next;
      last_num     <= last_num_next;
      p_acc        <= p_acc_next;
      p_dz         <= p_dz_next;
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && key_valid) begin
      kind_r  <= key.kind;
      value_r <= key.value;
    end
    if (out_load) begin
      res.accepted       <= p_acc;
      res.div_by_zero    <= p_dz;
      res.current_result <= cur;
    end
  end

endmodule
